/* hw/rtl/sida_pkg.sv */
// Shared types, character constants and microcode table for the decimal text converter.
`timescale 1ns / 1ps
`default_nettype none

package sida_pkg;

  localparam int unsigned MAG_W   = 32;
  localparam int unsigned NDIG    = 10;
  localparam int unsigned BCD_W   = 4 * NDIG;
  localparam int unsigned ITER_W  = 5;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [3:0] MAX_DIGITS = 4'd10;
  localparam logic [3:0] BCD_LIMIT  = 4'd5;
  localparam logic [3:0] BCD_ADJUST = 4'd3;
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(MAG_W - 1);

  // Microprogram step addresses
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DABBLE = 3'd1,
    ST_WIDTH  = 3'd2,
    ST_SIGN   = 3'd3,
    ST_DIGIT  = 3'd4
  } step_t;

  // Jump conditions: the sequencer goes to the target when the condition holds, else stays
  typedef enum logic [2:0] {
    COND_ALWAYS = 3'd0,
    COND_IN     = 3'd1,
    COND_ITER   = 3'd2,
    COND_SIGN   = 3'd3,
    COND_DIGIT  = 3'd4
  } cond_t;

  // One control word per step
  typedef struct packed {
    logic  ld;    // take a word from the input
    logic  dab;   // one shift-add-3 step
    logic  fmt;   // work out the digit count to send
    logic  sgn;   // send the minus sign if negative
    logic  dig;   // send one digit
    cond_t cond;
    step_t tgt;
  } ctrl_t;

  // Read-only microprogram
  function automatic ctrl_t ucode(step_t pc);
    ctrl_t cw;
    cw = '{ld: 1'b0, dab: 1'b0, fmt: 1'b0, sgn: 1'b0, dig: 1'b0,
           cond: COND_ALWAYS, tgt: ST_IDLE};
    unique case (pc)
      ST_IDLE: begin
        cw.ld   = 1'b1;
        cw.cond = COND_IN;
        cw.tgt  = ST_DABBLE;
      end
      ST_DABBLE: begin
        cw.dab  = 1'b1;
        cw.cond = COND_ITER;
        cw.tgt  = ST_WIDTH;
      end
      ST_WIDTH: begin
        cw.fmt  = 1'b1;
        cw.cond = COND_ALWAYS;
        cw.tgt  = ST_SIGN;
      end
      ST_SIGN: begin
        cw.sgn  = 1'b1;
        cw.cond = COND_SIGN;
        cw.tgt  = ST_DIGIT;
      end
      ST_DIGIT: begin
        cw.dig  = 1'b1;
        cw.cond = COND_DIGIT;
        cw.tgt  = ST_IDLE;
      end
      default: begin
        cw.cond = COND_ALWAYS;
        cw.tgt  = ST_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/signed_int_to_decimal_ascii.sv */
// Top level: microcoded signed binary to decimal ASCII text converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts a signed 32-bit value to decimal ASCII, one character per output word,
// with out_last on the final character. A negative value starts with '-'. With
// in_digit_count 0 the natural width is sent ("0" for zero); 1..10 sends exactly
// that many low digits with leading zeros, and larger counts act as 10. A value
// passes through these steps in order: taking the word, 32 shift-add-3 steps,
// sizing the text and one sign slot, spent whether or not a minus is sent; then
// the output register takes one digit per cycle while the output does not stall.
// A new value is taken only once the previous one's last character sits in the
// output register.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic signed [31:0] in_value,
  input  wire logic        [3:0]  in_digit_count,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic        [7:0]  out_text_char,
  output      logic               out_last
);

  // Sequencer and datapath registers
  step_t             pc_r, pc_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              neg_r, neg_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  ctrl_t             cw;
  logic              out_free;
  logic              in_take;
  logic              go;
  logic              emit_sign;
  logic              emit_dig;
  logic [BCD_W-1:0]  bcd_adj;
  logic [3:0]        natural;
  logic [3:0]        emit_cnt;
  logic [3:0]        cur_dig;

  assign cw       = ucode(pc_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_take  = cw.ld && in_valid;
  assign in_stall = !cw.ld;

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      if (bcd_r[4*k +: 4] >= BCD_LIMIT) begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4] + BCD_ADJUST;
      end else begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4];
      end
    end
  end

  // Natural width: position of the highest nonzero digit, at least one
  always_comb begin
    natural = 4'd1;
    for (int k = 0; k < NDIG; k++) begin
      if (bcd_r[4*k +: 4] != 4'd0) begin
        natural = 4'(k + 1);
      end
    end
  end

  assign emit_cnt = (cnt_r == 4'd0) ? natural : cnt_r;
  assign cur_dig  = bcd_r[4*idx_r +: 4];

  // Next step: jump to the target when the condition holds
  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS: go = 1'b1;
      COND_IN:     go = in_valid;
      COND_ITER:   go = (iter_r == LAST_ITER);
      COND_SIGN:   go = !neg_r || out_free;
      COND_DIGIT:  go = out_free && (idx_r == 4'd0);
      default:     go = 1'b1;
    endcase
    pc_nxt = go ? cw.tgt : pc_r;
  end

  // Datapath actions driven by the control word
  always_comb begin
    emit_sign     = cw.sgn && neg_r && out_free;
    emit_dig      = cw.dig && out_free;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    iter_nxt      = iter_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (in_take) begin
      neg_nxt  = in_value[MAG_W-1];
      mag_nxt  = in_value[MAG_W-1] ? (MAG_W'(0) - in_value) : in_value;
      bcd_nxt  = '0;
      iter_nxt = '0;
      cnt_nxt  = (in_digit_count > MAX_DIGITS) ? MAX_DIGITS : in_digit_count;
    end

    if (cw.dab) begin
      bcd_nxt  = {bcd_adj[BCD_W-2:0], mag_r[MAG_W-1]};
      mag_nxt  = {mag_r[MAG_W-2:0], 1'b0};
      iter_nxt = iter_r + ITER_W'(1);
    end

    if (cw.fmt) begin
      idx_nxt = emit_cnt - 4'd1;
    end

    if (emit_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_MINUS;
      out_last_nxt  = 1'b0;
    end

    if (emit_dig) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_ZERO + {4'd0, cur_dig};
      out_last_nxt  = (idx_r == 4'd0);
      if (idx_r != 4'd0) begin
        idx_nxt = idx_r - 4'd1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    iter_r     <= iter_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last      = out_last_r;

  // A taken word always starts the conversion loop
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (pc_r == ST_DABBLE))
    else $error("accepted word did not start conversion");

  // The iteration counter wraps exactly after 32 shift steps
  a_iter_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_WIDTH) |-> (iter_r == '0))
    else $error("conversion loop ran a wrong number of steps");

  // Digit index stays within the ten BCD digits
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_DIGIT) |-> (idx_r < MAX_DIGITS))
    else $error("digit index out of range");

  // Sent characters are a minus or a decimal digit
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_char_r == CHAR_MINUS) ||
                     ((out_char_r >= CHAR_ZERO) && (out_char_r <= CHAR_NINE))))
    else $error("character outside decimal set");

  // A minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_char_r == CHAR_MINUS)) |-> !out_last_r)
    else $error("minus sign marked last");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 1ps

module tb_top;
  import sida_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 100;

  // One value to convert, plus a flag that makes the sender wait for all text first
  typedef struct {
    logic signed [31:0] value;
    logic        [3:0]  digit_count;
    logic               drain;
  } value_word_t;

  // One expected text character
  typedef struct {
    logic [7:0] text_char;
    logic       last;
  } text_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_value = '0;
  logic        [3:0]  in_digit_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic        [7:0]  out_text_char;
  logic               out_last;

  value_word_t value_q[$];
  text_word_t  text_due[$];
  logic        text_busy = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int          fails = 0;

  signed_int_to_decimal_ascii dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_digit_count(in_digit_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_text_char (out_text_char),
    .out_last      (out_last)
  );

  always #6 clk = ~clk;

  // Expected characters for one value: optional '-', then digits high to low
  function automatic void predict_text(logic [31:0] raw, logic [3:0] count);
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  dig [NDIG];
    int          width;
    int          emit;
    text_word_t  w;
    neg = raw[31];
    mag = neg ? (32'd0 - raw) : raw;
    width = 1;
    for (int i = 0; i < NDIG; i++) begin
      dig[i] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      if (dig[i] != 4'd0) width = i + 1;
    end
    if (count == 4'd0) emit = width;
    else if (count > MAX_DIGITS) emit = MAX_DIGITS;
    else emit = count;
    if (neg) begin
      w.text_char = CHAR_MINUS;
      w.last = 1'b0;
      text_due.push_back(w);
    end
    for (int i = emit; i > 0; i--) begin
      w.text_char = CHAR_ZERO + 8'(dig[i-1]);
      w.last = (i == 1);
      text_due.push_back(w);
    end
  endfunction

  // Sender: holds a word until taken, may idle between words
  always @(posedge clk) begin
    value_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (value_q.size() != 0 && !(value_q[0].drain && (in_valid || text_busy)) &&
          $urandom_range(99) >= send_idle_pct) begin
        w = value_q.pop_front();
        in_valid <= 1'b1;
        in_value <= w.value;
        in_digit_count <= w.digit_count;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predict on input accept, compare on output accept
  always @(posedge clk) begin
    text_word_t w;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_text(in_value, in_digit_count);
      if (out_valid && !out_stall) begin
        if (text_due.size() == 0) begin
          $error("unexpected character 0x%02h last=%0b", out_text_char, out_last);
          fails++;
        end else begin
          w = text_due.pop_front();
          if (out_text_char !== w.text_char) begin
            $error("text_char: expected 0x%02h, got 0x%02h", w.text_char, out_text_char);
            fails++;
          end
          if (out_last !== w.last) begin
            $error("last: expected %0b, got %0b", w.last, out_last);
            fails++;
          end
        end
      end
      text_busy <= (text_due.size() != 0);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_word(logic signed [31:0] value, logic [3:0] count, logic drain);
    value_word_t w;
    w.value = value;
    w.digit_count = count;
    w.drain = drain;
    value_q.push_back(w);
  endtask

  // Random values: full range, small, around powers of ten, the extremes
  task automatic queue_random(int n, int drain_every);
    logic signed [31:0] v;
    logic [3:0]         count;
    int unsigned        p;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0, 1: v = $urandom();
        2: v = $urandom_range(999);
        3: begin
          p = 1;
          repeat ($urandom_range(9)) p = p * 10;
          v = p + $urandom_range(2) - 1;
        end
        4: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        default: v = $urandom_range(99999);
      endcase
      if ($urandom_range(1)) v = -v;
      count = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
      add_word(v, count, drain_every != 0 && (i % drain_every) == drain_every - 1);
    end
  endtask

  // Wait until everything sent has come back
  task automatic wait_idle();
    do @(negedge clk); while (value_q.size() != 0 || in_valid || text_busy);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero, extremes, truncation, padding, saturated count
    add_word(32'sd0, 4'd0, 1'b0);
    add_word(32'sd0, 4'd1, 1'b0);
    add_word(32'sd0, 4'd10, 1'b0);
    add_word(32'sd0, 4'd15, 1'b0);
    add_word(32'sh8000_0000, 4'd0, 1'b0);
    add_word(32'sh8000_0000, 4'd10, 1'b0);
    add_word(32'sh8000_0000, 4'd3, 1'b0);
    add_word(32'sh7fff_ffff, 4'd0, 1'b0);
    add_word(32'sh7fff_ffff, 4'd12, 1'b0);
    add_word(-32'sd1, 4'd0, 1'b0);
    add_word(-32'sd1, 4'd4, 1'b0);
    add_word(32'sd9, 4'd1, 1'b0);
    add_word(32'sd10, 4'd1, 1'b0);
    add_word(32'sd100, 4'd2, 1'b0);
    add_word(-32'sd100, 4'd2, 1'b0);
    add_word(32'sd1000000000, 4'd9, 1'b0);
    add_word(32'sd1000000000, 4'd0, 1'b0);
    add_word(32'sd999999999, 4'd10, 1'b0);
    add_word(-32'sd123, 4'd2, 1'b1);
    add_word(32'sd123456, 4'd3, 1'b0);
    add_word(32'sd4, 4'd11, 1'b0);
    add_word(32'sd42, 4'd14, 1'b0);
    wait_idle();

    // Random phases with different idling
    queue_random(55, 0);
    wait_idle();
    send_idle_pct = 58;
    queue_random(55, 0);
    wait_idle();
    send_idle_pct = 0;
    stall_pct = 58;
    queue_random(55, 0);
    wait_idle();

    // Long receiver hold-off while the sender keeps offering
    stall_pct = 0;
    holds_asked = 1;
    queue_random(28, 0);
    wait_idle();

    send_idle_pct = 25;
    stall_pct = 25;
    queue_random(55, 18);
    wait_idle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
